// File: sv/efdp_pkg.sv
`timescale 1ns / 1ps

package efdp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned LEN_W   = 20;
  localparam int unsigned DIST_W  = 40;
  localparam int unsigned REL_W   = 39;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Frame header bytes
  localparam logic [BYTE_W-1:0] HDR0 = 8'hAB;
  localparam logic [BYTE_W-1:0] HDR1 = 8'hCD;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_LENGTH_PER_REV = 1'b0
  } efdp_reg_e;

  // Frame assembler status toward the scaling pipeline
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } frame_t;

endpackage

// File: sv/efdp_if.sv
`timescale 1ns / 1ps

interface efdp_in_if;
  logic                          valid;
  logic                          ready;
  logic [efdp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efdp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          origin_frame;
  logic signed [efdp_pkg::DIST_W-1:0] absolute_distance;
  logic [efdp_pkg::REL_W-1:0]    relative_distance;

  modport source (output valid, output origin_frame, output absolute_distance,
                  output relative_distance, input ready);
  modport sink   (input valid, input origin_frame, input absolute_distance,
                  input relative_distance, output ready);
endinterface

// File: sv/efdp_frame_asm.sv
`timescale 1ns / 1ps

module efdp_frame_asm #(
  parameter int unsigned FRAME_BYTES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [efdp_pkg::BYTE_W-1:0] rx_byte_i,
  output efdp_pkg::frame_t            frame_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
  localparam int unsigned FIRST_CNT = 3;

  logic [IDX_W-1:0]                idx_q, idx_d;
  logic [efdp_pkg::BYTE_W-1:0]     cnt_q [4];
  logic [efdp_pkg::BYTE_W-1:0]     cnt_cur [4];
  logic                            hdr_bad;

  // Bytes of this frame, with the byte on the port forwarded in
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_cur[k] = (idx_q == IDX_W'(FIRST_CNT + k)) ? rx_byte_i : cnt_q[k];
    end
  end

  assign hdr_bad = ((idx_q == IDX_W'(0)) && (rx_byte_i != efdp_pkg::HDR0)) ||
                   ((idx_q == IDX_W'(1)) && (rx_byte_i != efdp_pkg::HDR1));

  always_comb begin
    idx_d         = idx_q;
    frame_o.done  = 1'b0;
    frame_o.count = {cnt_cur[2], cnt_cur[3], cnt_cur[0], cnt_cur[1]};
    if (accept_i) begin
      if (hdr_bad) begin
        idx_d = '0;
      end else if (idx_q == LAST_IDX) begin
        idx_d        = '0;
        frame_o.done = 1'b1;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = 0; k < 4; k++) begin
        cnt_q[k] <= cnt_cur[k];
      end
    end
  end

endmodule

// File: sv/encoder_frame_distance_parser.sv
`timescale 1ns / 1ps

// Encoder frame parser with distance scaling.
// Channels: in_i carries one received link byte per request (rx_byte);
// out_o carries one result per completed frame (origin_frame,
// absolute_distance, relative_distance). Both use valid/ready.
// length_per_rev is written over the APB port at byte address 0.
// Frames are FRAME_BYTES long and start with 0xAB 0xCD; a bad header byte
// drops the partial frame and is itself discarded.
// Throughput: one byte per cycle while in_i.ready is high. The result of a
// frame is registered in the multiply stage, which takes the 32x21 product
// when its last byte is accepted, and then in the output register, which
// takes scaling, origin update and the relative distance subtract.
// Reset: parser returns to the first header byte, origin is forgotten,
// stored origin and current distances and length_per_rev clear to zero, no result is pending.
// Stall: while a result waits on out_o, the frame in the multiply stage
// holds and in_i deasserts ready only if that stage is also occupied;
// bytes that do not end a frame are still taken whenever ready is high.
module encoder_frame_distance_parser #(
  parameter int unsigned FRAME_BYTES         = 10,
  parameter int unsigned COUNTS_PER_REV_LOG2 = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  efdp_in_if.sink                        in_i,
  efdp_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [efdp_pkg::PADDR_W-1:0]   paddr,
  input  logic [efdp_pkg::PDATA_W-1:0]   pwdata,
  output logic [efdp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned PROD_W = efdp_pkg::COUNT_W + efdp_pkg::LEN_W + 1;
  localparam int unsigned DW     = efdp_pkg::DIST_W;
  localparam int unsigned RW     = efdp_pkg::REL_W;

  // Signed 40-bit limits, sign-extended to the product width
  localparam logic signed [PROD_W-1:0] MAX_D = {{(PROD_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] MIN_D = {{(PROD_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // ---------------- configuration ----------------
  logic [efdp_pkg::LEN_W-1:0] len_q;
  logic                       reg_hit;

  assign reg_hit = (paddr[2] == efdp_pkg::REG_LENGTH_PER_REV);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(efdp_pkg::PDATA_W-efdp_pkg::LEN_W){1'b0}}, len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      len_q <= pwdata[efdp_pkg::LEN_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  logic out_free, in_accept, p1_valid_q, p1_move;

  // Output register can take a new result when empty or being drained
  assign out_free  = !out_o.valid || out_o.ready;
  assign in_i.ready = !p1_valid_q || out_free;
  assign in_accept = in_i.valid && in_i.ready;
  assign p1_move   = p1_valid_q && out_free;

  // ---------------- byte parsing ----------------
  efdp_pkg::frame_t frame;

  efdp_frame_asm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame_asm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (in_i.rx_byte),
    .frame_o   (frame)
  );

  // ---------------- stage 1: multiply ----------------
  logic signed [PROD_W-1:0] prod_d, p1_prod_q;

  assign prod_d = $signed(frame.count) * $signed({1'b0, len_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (in_accept && frame.done) begin
      p1_valid_q <= 1'b1;
    end else if (p1_move) begin
      p1_valid_q <= 1'b0;
    end
  end

  // A new frame loads only when the stage is empty or moving on
  always_ff @(posedge clk_i) begin
    if (in_accept && frame.done) begin
      p1_prod_q <= prod_d;
    end
  end

  // ---------------- stage 2: scale, origin, relative ----------------
  logic signed [PROD_W-1:0] shifted;
  logic signed [DW-1:0]     scaled;
  logic                     org_taken_q;
  logic signed [DW-1:0]     org_q, cur_q, org_new, cur_new;
  logic signed [DW:0]       diff;
  logic [RW-1:0]            rel;

  // Arithmetic shift floors toward minus infinity; then saturate to 40 bits
  assign shifted = p1_prod_q >>> COUNTS_PER_REV_LOG2;

  always_comb begin
    if (shifted > MAX_D) begin
      scaled = MAX_D[DW-1:0];
    end else if (shifted < MIN_D) begin
      scaled = MIN_D[DW-1:0];
    end else begin
      scaled = shifted[DW-1:0];
    end
  end

  assign org_new = org_taken_q ? org_q : scaled;
  assign cur_new = org_taken_q ? scaled : cur_q;
  assign diff    = {cur_new[DW-1], cur_new} - {org_new[DW-1], org_new};

  // Clamp at zero below, at all ones of 39 bits above
  always_comb begin
    if (diff[DW]) begin
      rel = '0;
    end else if (diff[DW-1]) begin
      rel = '1;
    end else begin
      rel = diff[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_taken_q <= 1'b0;
      org_q       <= '0;
      cur_q       <= '0;
      out_o.valid <= 1'b0;
    end else begin
      if (p1_move) begin
        org_taken_q <= 1'b1;
        org_q       <= org_new;
        cur_q       <= cur_new;
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_move) begin
      out_o.origin_frame      <= !org_taken_q;
      out_o.absolute_distance <= cur_new;
      out_o.relative_distance <= rel;
    end
  end

endmodule

// File: sv/efdp_checker.sv
`timescale 1ns / 1ps

module efdp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              origin_frame_i,
  input logic signed [efdp_pkg::DIST_W-1:0] absolute_distance_i,
  input logic [efdp_pkg::REL_W-1:0]        relative_distance_i
);

  logic seen_q;
  logic out_take;

  assign out_take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (out_take) begin
      seen_q <= 1'b1;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(origin_frame_i) &&
    $stable(absolute_distance_i) && $stable(relative_distance_i))
    else $error("result changed while stalled");

  // An origin frame shows an absolute distance of zero
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && origin_frame_i |-> absolute_distance_i == '0)
    else $error("origin frame shows nonzero absolute distance");

  // Only the first result after reset is an origin frame
  a_origin_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q |-> !origin_frame_i)
    else $error("second origin frame");

  // A rising result valid must follow an accepted input byte
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a preceding byte");

endmodule

bind encoder_frame_distance_parser efdp_checker u_efdp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .origin_frame_i      (out_o.origin_frame),
  .absolute_distance_i (out_o.absolute_distance),
  .relative_distance_i (out_o.relative_distance)
);
